// File: sv/assert_macros.svh
// Assertion macros shared by the request header parser RTL.
// Needs nothing else; SYNTH selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/hrhp_pkg.sv
// Package for the request header parser: phase, status and role codes,
// parser state type and byte class helpers. No dependencies.
package hrhp_pkg;

   localparam logic [3:0] PH_LEAD   = 4'd0;
   localparam logic [3:0] PH_METHOD = 4'd1;
   localparam logic [3:0] PH_GAP1   = 4'd2;
   localparam logic [3:0] PH_PATH   = 4'd3;
   localparam logic [3:0] PH_GAP2   = 4'd4;
   localparam logic [3:0] PH_PROTO  = 4'd5;
   localparam logic [3:0] PH_LINE   = 4'd6;
   localparam logic [3:0] PH_NAME   = 4'd7;
   localparam logic [3:0] PH_GAP3   = 4'd8;
   localparam logic [3:0] PH_VALUE  = 4'd9;
   localparam logic [3:0] PH_STOP   = 4'd10;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_REJ  = 2'd2;
   localparam logic [1:0] ST_END  = 2'd3;

   localparam logic [1:0] ROLE_IGNORED = 2'd0;
   localparam logic [1:0] ROLE_PATH    = 2'd1;
   localparam logic [1:0] ROLE_NAME    = 2'd2;
   localparam logic [1:0] ROLE_VALUE   = 2'd3;

   localparam logic [6:0] HDR_CAP       = 7'd125;
   localparam logic [6:0] MAX_HDR_RESET = 7'd125;
   localparam logic [3:0] METH_LEN      = 4'd3;
   localparam logic [3:0] PROTO_LEN     = 4'd8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef struct packed {
      logic [3:0] phase;
      logic [3:0] match_count;
      logic       mismatch;
      logic [6:0] hdr_count;
      logic       meth_good;
      logic       proto_good;
      logic [1:0] stat;
   } parse_state_type;

   function automatic logic [7:0] meth_char(input logic [1:0] idx);
      unique case (idx)
         2'd0:    meth_char = 8'h47; // G
         2'd1:    meth_char = 8'h45; // E
         default: meth_char = 8'h54; // T
      endcase
   endfunction

   function automatic logic [7:0] proto_char(input logic [2:0] idx);
      unique case (idx)
         3'd0:    proto_char = 8'h48; // H
         3'd1:    proto_char = 8'h54; // T
         3'd2:    proto_char = 8'h54; // T
         3'd3:    proto_char = 8'h50; // P
         3'd4:    proto_char = 8'h2F; // /
         3'd5:    proto_char = 8'h31; // 1
         3'd6:    proto_char = 8'h2E; // .
         default: proto_char = 8'h31; // 1
      endcase
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == CH_TAB) || (b == CH_SPACE);
   endfunction

   function automatic logic is_newline(input logic [7:0] b);
      is_newline = (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      is_letter = (b >= CH_UPPER_A) && (b <= CH_LOWER_Z);
   endfunction

endpackage

// File: sv/hrhp_step.sv
// Per-byte parser step: next parser state, role and field end for one byte.
// Depends on hrhp_pkg.
module hrhp_step import hrhp_pkg::*; (
   input  logic [7:0]      byte_in,
   input  logic [6:0]      limit,
   input  parse_state_type cur,
   output parse_state_type nxt,
   output logic [1:0]      role,
   output logic            field_done
);

   logic       blank, newline, letter, at_end;
   logic [3:0] pm;
   logic       pmm;

   assign blank   = is_blank(byte_in);
   assign newline = is_newline(byte_in);
   assign letter  = is_letter(byte_in);
   assign at_end  = (byte_in == CH_NUL);

   // protocol match starts afresh on the first byte after the gap
   assign pm  = (cur.phase == PH_GAP2) ? 4'd0 : cur.match_count;
   assign pmm = (cur.phase == PH_GAP2) ? 1'b0 : cur.mismatch;

   always_comb begin
      nxt        = cur;
      role       = ROLE_IGNORED;
      field_done = 1'b0;
      unique case (cur.phase) inside
         PH_LEAD: begin
            if (!(blank || newline)) begin
               if (byte_in == meth_char(2'd0)) begin
                  nxt.match_count = 4'd1;
                  nxt.phase       = PH_METHOD;
               end else begin
                  nxt.stat  = ST_REJ;
                  nxt.phase = PH_STOP;
               end
            end
         end
         PH_METHOD: begin
            if (cur.match_count < METH_LEN) begin
               if (byte_in == meth_char(cur.match_count[1:0])) begin
                  nxt.match_count = cur.match_count + 4'd1;
               end else begin
                  nxt.stat  = ST_REJ;
                  nxt.phase = PH_STOP;
               end
            end else if (letter) begin
               nxt.stat  = ST_REJ;
               nxt.phase = PH_STOP;
            end else begin
               nxt.meth_good = 1'b1;
               if (at_end) begin
                  nxt.stat  = ST_END;
                  nxt.phase = PH_STOP;
               end else if (blank) begin
                  nxt.phase = PH_GAP1;
               end else begin
                  role      = ROLE_PATH;
                  nxt.phase = PH_PATH;
               end
            end
         end
         PH_GAP1: begin
            if (at_end) begin
               nxt.stat  = ST_END;
               nxt.phase = PH_STOP;
            end else if (blank) begin
               nxt.phase = PH_GAP1;
            end else begin
               role      = ROLE_PATH;
               nxt.phase = PH_PATH;
            end
         end
         PH_PATH: begin
            if (at_end) begin
               nxt.stat  = ST_END;
               nxt.phase = PH_STOP;
            end else if (blank) begin
               field_done = 1'b1;
               nxt.phase  = PH_GAP2;
            end else begin
               role = ROLE_PATH;
            end
         end
         PH_GAP2, PH_PROTO: begin
            if (at_end) begin
               nxt.stat  = ST_END;
               nxt.phase = PH_STOP;
            end else if (!(cur.phase == PH_GAP2 && blank)) begin
               nxt.phase       = PH_PROTO;
               nxt.match_count = pm;
               nxt.mismatch    = pmm;
               if (newline) begin
                  nxt.proto_good = !pmm && (pm == PROTO_LEN);
                  nxt.phase      = PH_LINE;
               end else if (pm >= PROTO_LEN) begin
                  nxt.mismatch = 1'b1;
               end else begin
                  nxt.mismatch    = pmm | (byte_in != proto_char(pm[2:0]));
                  nxt.match_count = pm + 4'd1;
               end
            end
         end
         PH_LINE: begin
            if (!newline) begin
               if (at_end || cur.hdr_count >= limit) begin
                  nxt.stat  = ST_DONE;
                  nxt.phase = PH_STOP;
               end else begin
                  nxt.hdr_count = cur.hdr_count + 7'd1;
                  if (byte_in == CH_COLON) begin
                     field_done = 1'b1;
                     nxt.phase  = PH_GAP3;
                  end else begin
                     role      = ROLE_NAME;
                     nxt.phase = PH_NAME;
                  end
               end
            end
         end
         PH_NAME: begin
            if (at_end) begin
               nxt.stat  = ST_END;
               nxt.phase = PH_STOP;
            end else if (byte_in == CH_COLON) begin
               field_done = 1'b1;
               nxt.phase  = PH_GAP3;
            end else begin
               role = ROLE_NAME;
            end
         end
         PH_GAP3, PH_VALUE: begin
            if (at_end) begin
               nxt.stat  = ST_END;
               nxt.phase = PH_STOP;
            end else if (newline) begin
               field_done = 1'b1;
               nxt.phase  = PH_LINE;
            end else if (!(cur.phase == PH_GAP3 && blank)) begin
               role      = ROLE_VALUE;
               nxt.phase = PH_VALUE;
            end
         end
         default: begin
            nxt.phase = PH_STOP;
         end
      endcase
   end

endmodule

// File: sv/http_request_header_parser.sv
// Request header parser top level: input register, per-byte step, result register.
// Depends on hrhp_pkg, hrhp_step and assert_macros.svh.
//
//   channel  dir  handshake           payload
//   req_     in   req_valid/req_stall req_byte_in
//   rsp_     out  rsp_valid/rsp_stall rsp_byte_out, rsp_role, rsp_field_done,
//                                     rsp_header_index, rsp_method_ok,
//                                     rsp_proto_ok, rsp_status
//   csr_     in   csr_valid/csr_ready csr_max_headers
//
// One byte per cycle unless rsp_stall holds; a byte goes via both registers to rsp_.
// The parser state update sits between the input and result registers.
// Synchronous reset clears state, valid flags and sets the header limit to 125.
// A stalled result holds; the input register then holds one byte before req_stall rises.
// csr_ready is always high.
module http_request_header_parser import hrhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_role,
   output logic       rsp_field_done,
   output logic [6:0] rsp_header_index,
   output logic       rsp_method_ok,
   output logic       rsp_proto_ok,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_max_headers
);

   `include "assert_macros.svh"

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   parse_state_type st_ff, st_in;
   logic [6:0]      max_headers_ff;
   logic [6:0]      limit;
   logic [1:0]      role_in;
   logic            done_in;
   logic            out_free, advance;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic [1:0]      rsp_role_ff;
   logic            rsp_done_ff;
   logic [6:0]      rsp_index_ff;
   logic            rsp_meth_ff;
   logic            rsp_proto_ff;
   logic [1:0]      rsp_status_ff;

   assign limit     = (max_headers_ff > HDR_CAP) ? HDR_CAP : max_headers_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   hrhp_step u_step (
      .byte_in    (in_byte_ff),
      .limit      (limit),
      .cur        (st_ff),
      .nxt        (st_in),
      .role       (role_in),
      .field_done (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_headers_ff <= MAX_HDR_RESET;
      end else if (csr_valid && csr_ready) begin
         max_headers_ff <= csr_max_headers;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: PH_LEAD, match_count: 4'd0, mismatch: 1'b0,
                    hdr_count: 7'd0, meth_good: 1'b0, proto_good: 1'b0,
                    stat: ST_RUN};
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff   <= in_byte_ff;
         rsp_role_ff   <= role_in;
         rsp_done_ff   <= done_in;
         rsp_index_ff  <= st_in.hdr_count;
         rsp_meth_ff   <= st_in.meth_good;
         rsp_proto_ff  <= st_in.proto_good;
         rsp_status_ff <= st_in.stat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_byte_ff;
   assign rsp_role         = rsp_role_ff;
   assign rsp_field_done   = rsp_done_ff;
   assign rsp_header_index = rsp_index_ff;
   assign rsp_method_ok    = rsp_meth_ff;
   assign rsp_proto_ok     = rsp_proto_ff;
   assign rsp_status       = rsp_status_ff;

   `ASSERT_IMPLIES(a_stop_phase, clock, reset, st_ff.stat != ST_RUN, st_ff.phase == PH_STOP)
   `ASSERT_IMPLIES(a_hdr_cap, clock, reset, 1'b1, st_ff.hdr_count <= HDR_CAP)
   `ASSERT_IMPLIES(a_proto_after_meth, clock, reset, st_ff.proto_good, st_ff.meth_good)
   `ASSERT_IMPLIES(a_done_ignored, clock, reset, rsp_valid_ff && rsp_done_ff,
                   rsp_role_ff == ROLE_IGNORED)

endmodule

// File: tb/header_tag_checker.sv
`timescale 1ns / 100ps
// Watches the request and result channels of the request header parser, predicts the
// tag of every byte and compares it. Depends on hrhp_pkg only.
module header_tag_checker import hrhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_byte_out,
   input  logic [1:0] rsp_role,
   input  logic       rsp_field_done,
   input  logic [6:0] rsp_header_index,
   input  logic       rsp_method_ok,
   input  logic       rsp_proto_ok,
   input  logic [1:0] rsp_status,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_max_headers,
   output int         tag_errors,
   output int         tags_pending
);

   typedef enum logic [2:0] {
      CL_END, CL_NEWLINE, CL_BLANK, CL_LETTER, CL_COLON, CL_OTHER
   } byte_class_type;

   localparam logic [23:0] METHOD_TEXT = "GET";
   localparam logic [63:0] PROTO_TEXT  = "HTTP/1.1";

   typedef struct packed {
      logic [7:0] byte_out;
      logic [1:0] role;
      logic       field_done;
      logic [6:0] hdr_index;
      logic       method_ok;
      logic       proto_ok;
      logic [1:0] status;
   } tag_type;

   tag_type    tags_due[$];
   logic [6:0] hdr_limit;
   logic [3:0] phase;
   logic [3:0] match_len;
   logic       proto_bad;
   logic [6:0] hdr_count;
   logic       meth_seen;
   logic       proto_seen;
   logic [1:0] stat;

   function automatic byte_class_type class_of(input logic [7:0] b);
      if (b == CH_NUL) return CL_END;
      if (b == CH_LF || b == CH_CR) return CL_NEWLINE;
      if (b == CH_TAB || b == CH_SPACE) return CL_BLANK;
      if (b == CH_COLON) return CL_COLON;
      if (b >= CH_UPPER_A && b <= CH_LOWER_Z) return CL_LETTER;
      return CL_OTHER;
   endfunction

   task automatic halt(input logic [1:0] s);
      stat  = s;
      phase = PH_STOP;
   endtask

   task automatic open_path(input byte_class_type c, inout tag_type t);
      if (c == CL_END) halt(ST_END);
      else if (c == CL_BLANK) phase = PH_GAP1;
      else begin
         t.role = ROLE_PATH;
         phase  = PH_PATH;
      end
   endtask

   task automatic open_name(input byte_class_type c, inout tag_type t);
      if (c == CL_END) halt(ST_END);
      else if (c == CL_COLON) begin
         t.field_done = 1'b1;
         phase        = PH_GAP3;
      end else begin
         t.role = ROLE_NAME;
         phase  = PH_NAME;
      end
   endtask

   task automatic tag_byte(input logic [7:0] b, output tag_type t);
      byte_class_type c;
      logic [6:0]     limit;
      c     = class_of(b);
      limit = (hdr_limit > HDR_CAP) ? HDR_CAP : hdr_limit;
      t     = '0;
      t.role = ROLE_IGNORED;
      case (phase)
         PH_LEAD: begin
            if (c != CL_BLANK && c != CL_NEWLINE) begin
               if (b == METHOD_TEXT[23:16]) begin
                  match_len = 4'd1;
                  phase     = PH_METHOD;
               end else halt(ST_REJ);
            end
         end
         PH_METHOD: begin
            if (match_len < METH_LEN) begin
               if (b == METHOD_TEXT[8 * (2 - int'(match_len)) +: 8]) match_len++;
               else halt(ST_REJ);
            end else if (c == CL_LETTER) begin
               halt(ST_REJ);
            end else begin
               meth_seen = 1'b1;
               open_path(c, t);
            end
         end
         PH_GAP1: open_path(c, t);
         PH_PATH: begin
            if (c == CL_END) halt(ST_END);
            else if (c == CL_BLANK) begin
               t.field_done = 1'b1;
               phase        = PH_GAP2;
            end else t.role = ROLE_PATH;
         end
         PH_GAP2, PH_PROTO: begin
            if (c == CL_END) halt(ST_END);
            else if (!(phase == PH_GAP2 && c == CL_BLANK)) begin
               if (phase == PH_GAP2) begin
                  match_len = '0;
                  proto_bad = 1'b0;
                  phase     = PH_PROTO;
               end
               if (c == CL_NEWLINE) begin
                  proto_seen = !proto_bad && match_len == PROTO_LEN;
                  phase      = PH_LINE;
               end else if (match_len >= PROTO_LEN) begin
                  proto_bad = 1'b1;
               end else begin
                  if (b != PROTO_TEXT[8 * (7 - int'(match_len)) +: 8]) proto_bad = 1'b1;
                  match_len++;
               end
            end
         end
         PH_LINE: begin
            if (c != CL_NEWLINE) begin
               if (c == CL_END || hdr_count >= limit) halt(ST_DONE);
               else begin
                  hdr_count++;
                  open_name(c, t);
               end
            end
         end
         PH_NAME: open_name(c, t);
         PH_GAP3, PH_VALUE: begin
            if (c == CL_END) halt(ST_END);
            else if (c == CL_NEWLINE) begin
               t.field_done = 1'b1;
               phase        = PH_LINE;
            end else if (!(phase == PH_GAP3 && c == CL_BLANK)) begin
               t.role = ROLE_VALUE;
               phase  = PH_VALUE;
            end
         end
         default: phase = PH_STOP;
      endcase
      t.byte_out  = b;
      t.hdr_index = hdr_count;
      t.method_ok = meth_seen;
      t.proto_ok  = proto_seen;
      t.status    = stat;
   endtask

   always @(posedge clock) begin
      tag_type want;
      tag_type got;
      if (reset) begin
         tags_due.delete();
         hdr_limit  = MAX_HDR_RESET;
         phase      = PH_LEAD;
         match_len  = '0;
         proto_bad  = 1'b0;
         hdr_count  = '0;
         meth_seen  = 1'b0;
         proto_seen = 1'b0;
         stat       = ST_RUN;
      end else begin
         if (csr_valid && csr_ready) hdr_limit = csr_max_headers;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_byte_out, rsp_role, rsp_field_done, rsp_header_index,
                   rsp_method_ok, rsp_proto_ok, rsp_status};
            if (tags_due.size() == 0) begin
               if (tag_errors < 10)
                  $display("%0t: result transfer with no tag due, byte %h", $time, rsp_byte_out);
               tag_errors++;
            end else begin
               want = tags_due.pop_front();
               if (got !== want) begin
                  if (tag_errors < 10) begin
                     $display("%0t: tag mismatch", $time);
                     $display(
                        "  expected byte %h role %0d done %0d index %0d method %0d proto %0d status %0d",
                        want.byte_out, want.role, want.field_done, want.hdr_index,
                        want.method_ok, want.proto_ok, want.status);
                     $display(
                        "  got      byte %h role %0d done %0d index %0d method %0d proto %0d status %0d",
                        got.byte_out, got.role, got.field_done, got.hdr_index,
                        got.method_ok, got.proto_ok, got.status);
                  end
                  tag_errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            tag_byte(req_byte_in, want);
            tags_due.push_back(want);
         end
      end
      tags_pending = tags_due.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the request header parser testbench: clock, reset, request byte stream,
// result back-pressure and verdict. Depends on hrhp_pkg, the parser and header_tag_checker.
module testbench;
   import hrhp_pkg::*;

   localparam int ITEM_TARGET     = 1750;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int LINES_PER_PHASE = 10;
   localparam int MAX_LINES       = 100;
   localparam int LONG_HOLD       = 300;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in      = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_byte_out;
   logic [1:0] rsp_role;
   logic       rsp_field_done;
   logic [6:0] rsp_header_index;
   logic       rsp_method_ok;
   logic       rsp_proto_ok;
   logic [1:0] rsp_status;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_max_headers  = 7'd0;

   int tag_errors;
   int tags_pending;
   int bytes_sent;
   int lines_sent;
   int cycle_count;
   bit idle_on;
   bit stall_on;
   bit long_hold;

   http_request_header_parser i_dut (.*);

   header_tag_checker i_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tags_pending != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [6:0] v);
      drain();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_max_headers <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_header(input int name_max, input int value_max);
      logic [7:0] b;
      repeat ($urandom_range(0, name_max)) begin
         do b = text_byte(); while (b == CH_NUL || b == CH_COLON);
         send_byte(b);
      end
      send_byte(CH_COLON);
      repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      repeat ($urandom_range(0, value_max)) begin
         do b = text_byte(); while (b == CH_NUL || b == CH_CR || b == CH_LF);
         send_byte(b);
      end
      repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      lines_sent++;
   endtask

   initial begin
      int batch;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_limit(7'd127);

      // request line with odd path bytes, then an empty header
      idle_on  = 1'b1;
      stall_on = 1'b1;
      send_text(" \n\t");
      send_text("GET");
      if ($urandom_range(0, 1)) send_byte(CH_SPACE);
      send_text("/");
      send_byte(8'hFF);
      send_byte(CH_COLON);
      send_text(" \t");
      case ($urandom_range(0, 9))
         6:       send_text("HTTP/1.0");
         7:       send_text("HTTP/1.11");
         8:       ;
         9:       send_text("HTTP/1.");
         default: send_text("HTTP/1.1");
      endcase
      send_text("\r\n");
      send_text(":\n");
      lines_sent++;

      batch = 0;
      while (bytes_sent < ITEM_TARGET && lines_sent < MAX_LINES) begin
         write_limit(7'($urandom_range(lines_sent + LINES_PER_PHASE + 1, 127)));
         idle_on  = bytes_sent < ITEM_TARGET - 250 && $urandom_range(0, 3) != 0;
         stall_on = bytes_sent < ITEM_TARGET - 250 && $urandom_range(0, 3) != 0;
         if (batch == 2) long_hold = 1'b1;
         repeat (LINES_PER_PHASE) send_header(8, 24);
         batch++;
      end

      idle_on  = 1'b0;
      stall_on = 1'b0;
      drain();
      case ($urandom_range(0, 2))
         0: send_byte(CH_NUL);
         1: begin
            send_text("Ab");
            if ($urandom_range(0, 1)) send_text(": v");
            send_byte(CH_NUL);
         end
         default: begin
            write_limit(7'd0);
            send_header(4, 4);
         end
      endcase
      // parser has stopped; the limit and further bytes must change nothing
      write_limit(7'd0);
      repeat (24) send_byte(8'($urandom_range(0, 255)));

      drain();
      repeat (8) @(posedge clock);
      if (tag_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
